>>> design/sar_pkg.sv
// ----------------------------------------------------------------------------
// Slot and byte ring allocator package
// Shared types, codes and sizes for the allocator and its entry memory.
// ----------------------------------------------------------------------------
`default_nettype none
package sar_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W     = 4;
  localparam int FCNT_W     = 5;
  localparam int POS_W      = 24;
  localparam int SEQ_W      = 8;
  localparam logic [20:0] RING_LIMIT = 21'd1048576;

  localparam logic [1:0] CMD_ACQUIRE  = 2'd0;
  localparam logic [1:0] CMD_ROLLBACK = 2'd1;
  localparam logic [1:0] CMD_RELEASE  = 2'd2;
  localparam logic [1:0] CMD_VIEW     = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_LARGE = 3'd1;
  localparam logic [2:0] ST_NO_SLOT   = 3'd2;
  localparam logic [2:0] ST_NO_BYTES  = 3'd3;
  localparam logic [2:0] ST_REJECTED  = 3'd4;

  localparam logic REG_CAPACITY    = 1'b0;
  localparam logic REG_MAX_PAYLOAD = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  slot_number;
    logic [15:0] key_length;
    logic [15:0] value_length;
    logic [20:0] admission_amount;
  } in_word_t;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  status_code;
    logic [3:0]  granted_slot;
    logic [19:0] ring_offset;
    logic [15:0] stored_key_length;
    logic [15:0] stored_value_length;
    logic [20:0] stored_admission;
    logic [20:0] ring_bytes_used;
    logic [20:0] admission_used;
  } out_word_t;

  typedef struct packed {
    logic [SEQ_W-1:0] sequence_no;
    logic [POS_W-1:0] begin_pos;
    logic [POS_W-1:0] end_pos;
    logic [19:0]      offset;
    logic [15:0]      key_len;
    logic [15:0]      value_len;
    logic [20:0]      admission;
  } entry_t;

endpackage
`default_nettype wire

>>> design/sar_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module sar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> design/slot_and_byte_ring_allocator_unit.sv
// ----------------------------------------------------------------------------
// Slot and byte ring allocator
// Leases slots from a free-slot stack and places payloads in a byte ring.
// ----------------------------------------------------------------------------
// Each word passes through S_IDLE, which reads its slot entry from the entry
// RAM as the word is taken, and S_EXEC, which checks it and writes it back.
// The result is registered in S_EXEC; a new word is taken while it is shown.
// The receiver cannot stall, so results never hold off the input.
// Synchronous reset restores the registers, the free stack and the counters
// and clears every occupied bit; the entry RAM itself needs no clearing.
`default_nettype none
module slot_and_byte_ring_allocator_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire sar_pkg::in_word_t in_word,
  output logic                   out_valid,
  output sar_pkg::out_word_t     out_word,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic [20:0]       cfg_data
);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state_r;
  sar_pkg::in_word_t cmd_r;
  sar_pkg::out_word_t out_r, out_nxt;
  logic out_valid_r;
  logic [20:0] capacity_r;
  logic [15:0] max_payload_r;
  logic [sar_pkg::SLOT_W-1:0] stack_r [sar_pkg::SLOT_COUNT];
  logic [sar_pkg::FCNT_W-1:0] fcount_r, fcount_nxt;
  logic [sar_pkg::SLOT_COUNT-1:0] occupied_r, occupied_nxt;
  logic [sar_pkg::POS_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [19:0] hoff_r, hoff_nxt;
  logic [sar_pkg::SEQ_W-1:0] issue_r, issue_nxt, retire_r, retire_nxt;
  logic [20:0] adm_total_r, adm_total_nxt;

  logic [sar_pkg::SLOT_W-1:0] top_slot, rd_addr;
  logic [sar_pkg::FCNT_W-1:0] top_idx;
  sar_pkg::entry_t rd_entry, wr_entry;
  logic wr_en, push;
  logic [20:0] cap, maxp, used, next_off;
  logic [16:0] pay;
  logic [21:0] adm_sum, byte_sum;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  assign top_idx  = fcount_r - sar_pkg::FCNT_W'(1);
  assign top_slot = stack_r[top_idx[sar_pkg::SLOT_W-1:0]];
  assign rd_addr  = (in_word.command == sar_pkg::CMD_ACQUIRE) ? top_slot
                                                              : in_word.slot_number;

  sar_ram #(.WIDTH($bits(sar_pkg::entry_t)), .DEPTH(sar_pkg::SLOT_COUNT)) u_entry_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (top_slot),
    .wr_data (wr_entry),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  assign cap      = (capacity_r > sar_pkg::RING_LIMIT) ? sar_pkg::RING_LIMIT : capacity_r;
  assign maxp     = ({5'd0, max_payload_r} < cap) ? {5'd0, max_payload_r} : cap;
  assign pay      = {1'b0, cmd_r.key_length} + {1'b0, cmd_r.value_length};
  assign used     = 21'(head_r - tail_r);
  assign adm_sum  = {1'b0, adm_total_r} + {1'b0, cmd_r.admission_amount};
  assign byte_sum = {1'b0, used} + {5'd0, pay};
  assign next_off = ({1'b0, hoff_r} + {4'd0, pay} >= cap) ?
                    ({1'b0, hoff_r} + {4'd0, pay} - cap) : ({1'b0, hoff_r} + {4'd0, pay});

  always_comb begin
    fcount_nxt    = fcount_r;
    occupied_nxt  = occupied_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    hoff_nxt      = hoff_r;
    issue_nxt     = issue_r;
    retire_nxt    = retire_r;
    adm_total_nxt = adm_total_r;
    wr_en         = 1'b0;
    push          = 1'b0;
    out_nxt       = '0;
    out_nxt.status_code = sar_pkg::ST_REJECTED;
    wr_entry.sequence_no = issue_r;
    wr_entry.begin_pos   = head_r;
    wr_entry.end_pos     = head_r + sar_pkg::POS_W'(pay);
    wr_entry.offset      = hoff_r;
    wr_entry.key_len     = cmd_r.key_length;
    wr_entry.value_len   = cmd_r.value_length;
    wr_entry.admission   = cmd_r.admission_amount;
    unique case (cmd_r.command)
      sar_pkg::CMD_ACQUIRE: begin
        if ({4'd0, pay} > maxp || cmd_r.admission_amount < {4'd0, pay} ||
            cmd_r.admission_amount > cap) begin
          out_nxt.status_code = sar_pkg::ST_TOO_LARGE;
        end else if (fcount_r == '0) begin
          out_nxt.status_code = sar_pkg::ST_NO_SLOT;
        end else if (adm_sum > {1'b0, cap} || byte_sum > {1'b0, cap}) begin
          out_nxt.status_code = sar_pkg::ST_NO_BYTES;
        end else if (occupied_r[top_slot]) begin
          out_nxt.status_code = sar_pkg::ST_NO_SLOT;
        end else begin
          wr_en                  = (state_r == S_EXEC);
          fcount_nxt             = top_idx;
          occupied_nxt[top_slot] = 1'b1;
          issue_nxt              = issue_r + sar_pkg::SEQ_W'(1);
          head_nxt               = wr_entry.end_pos;
          hoff_nxt               = next_off[19:0];
          adm_total_nxt          = adm_sum[20:0];
          out_nxt.accepted            = 1'b1;
          out_nxt.status_code         = sar_pkg::ST_OK;
          out_nxt.granted_slot        = top_slot;
          out_nxt.ring_offset         = hoff_r;
          out_nxt.stored_key_length   = cmd_r.key_length;
          out_nxt.stored_value_length = cmd_r.value_length;
          out_nxt.stored_admission    = cmd_r.admission_amount;
        end
      end
      sar_pkg::CMD_ROLLBACK: begin
        if (occupied_r[cmd_r.slot_number] && rd_entry.admission == cmd_r.admission_amount &&
            rd_entry.sequence_no + sar_pkg::SEQ_W'(1) == issue_r &&
            rd_entry.end_pos == head_r) begin
          head_nxt      = rd_entry.begin_pos;
          hoff_nxt      = rd_entry.offset;
          issue_nxt     = issue_r - sar_pkg::SEQ_W'(1);
          adm_total_nxt = adm_total_r - rd_entry.admission;
          push          = 1'b1;
        end
      end
      sar_pkg::CMD_RELEASE: begin
        if (occupied_r[cmd_r.slot_number] && rd_entry.sequence_no == retire_r &&
            rd_entry.begin_pos == tail_r && rd_entry.admission <= adm_total_r) begin
          tail_nxt      = rd_entry.end_pos;
          retire_nxt    = retire_r + sar_pkg::SEQ_W'(1);
          adm_total_nxt = adm_total_r - rd_entry.admission;
          push          = 1'b1;
        end
      end
      sar_pkg::CMD_VIEW: begin
        if (occupied_r[cmd_r.slot_number]) begin
          out_nxt.accepted            = 1'b1;
          out_nxt.status_code         = sar_pkg::ST_OK;
          out_nxt.granted_slot        = cmd_r.slot_number;
          out_nxt.ring_offset         = rd_entry.offset;
          out_nxt.stored_key_length   = rd_entry.key_len;
          out_nxt.stored_value_length = rd_entry.value_len;
          out_nxt.stored_admission    = rd_entry.admission;
        end
      end
      default: begin
      end
    endcase
    if (push) begin
      occupied_nxt[cmd_r.slot_number] = 1'b0;
      out_nxt.accepted    = 1'b1;
      out_nxt.status_code = sar_pkg::ST_OK;
      if (fcount_r < sar_pkg::FCNT_W'(sar_pkg::SLOT_COUNT)) begin
        fcount_nxt = fcount_r + sar_pkg::FCNT_W'(1);
      end
    end
    out_nxt.ring_bytes_used = 21'(head_nxt - tail_nxt);
    out_nxt.admission_used  = adm_total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cmd_r         <= '0;
      out_valid_r   <= 1'b0;
      capacity_r    <= sar_pkg::RING_LIMIT;
      max_payload_r <= 16'd4096;
      fcount_r      <= sar_pkg::FCNT_W'(sar_pkg::SLOT_COUNT);
      occupied_r    <= '0;
      head_r        <= '0;
      tail_r        <= '0;
      hoff_r        <= '0;
      issue_r       <= '0;
      retire_r      <= '0;
      adm_total_r   <= '0;
      for (int i = 0; i < sar_pkg::SLOT_COUNT; i++) begin
        stack_r[i] <= sar_pkg::SLOT_W'(sar_pkg::SLOT_COUNT - 1 - i);
      end
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          sar_pkg::REG_CAPACITY:    capacity_r    <= cfg_data;
          sar_pkg::REG_MAX_PAYLOAD: max_payload_r <= cfg_data[15:0];
          default: begin
          end
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r   <= in_word;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          fcount_r    <= fcount_nxt;
          occupied_r  <= occupied_nxt;
          head_r      <= head_nxt;
          tail_r      <= tail_nxt;
          hoff_r      <= hoff_nxt;
          issue_r     <= issue_nxt;
          retire_r    <= retire_nxt;
          adm_total_r <= adm_total_nxt;
          if (push && fcount_r < sar_pkg::FCNT_W'(sar_pkg::SLOT_COUNT)) begin
            stack_r[fcount_r[sar_pkg::SLOT_W-1:0]] <= cmd_r.slot_number;
          end
          out_r       <= out_nxt;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
